// ----- hdl/eyepc_pkg.sv -----
// Shared constants and codes for the eye pixel compositor.
`default_nettype none
package eyepc_pkg;

  localparam int SCREEN_SIZE   = 128;
  localparam int SCLERA_SIZE   = 200;
  localparam int IRIS_SIZE     = 80;
  localparam int IRIS_MAP_COLS = 512;
  localparam int IRIS_MAP_ROWS = 80;

  localparam int LID_DEPTH     = SCREEN_SIZE * SCREEN_SIZE;
  localparam int SCLERA_DEPTH  = SCLERA_SIZE * SCLERA_SIZE;
  localparam int POLAR_DEPTH   = IRIS_SIZE * IRIS_SIZE;
  localparam int TEXTURE_DEPTH = IRIS_MAP_COLS * IRIS_MAP_ROWS;

  localparam int LID_AW = $clog2(LID_DEPTH);
  localparam int SCL_AW = $clog2(SCLERA_DEPTH);
  localparam int POL_AW = $clog2(POLAR_DEPTH);
  localparam int TEX_AW = $clog2(TEXTURE_DEPTH);
  localparam int LID_XW = $clog2(SCREEN_SIZE);
  localparam int COL_W  = $clog2(IRIS_MAP_COLS);

  // iris window origin inside the sclera image
  localparam int IRIS_ORG = (SCLERA_SIZE - IRIS_SIZE) / 2;

  // sclera coordinate: 7-bit offset plus 7-bit screen position
  localparam int SX_W   = 8;
  localparam int SCALE_W = 10;
  localparam int RAD_W   = 7;
  localparam int ANG_W   = 9;
  localparam int PROD_W  = SCALE_W + RAD_W;
  localparam int DIST_W  = PROD_W - 7;

  localparam int SCALE_DIV   = 128;
  localparam int ANG_DIV     = 512;
  localparam logic [7:0] THR_CLOSED = 8'hFF;
  localparam logic [15:0] BLACK     = 16'h0000;

  typedef enum logic [2:0] {
    OP_LOWER_LID = 3'd0,
    OP_UPPER_LID = 3'd1,
    OP_SCLERA    = 3'd2,
    OP_POLAR     = 3'd3,
    OP_TEXTURE   = 3'd4,
    OP_RENDER    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_IRIS_SCALE   = 3'd0,
    REG_VIEW_X       = 3'd1,
    REG_VIEW_Y       = 3'd2,
    REG_UPPER_THR    = 3'd3,
    REG_LOWER_THR    = 3'd4,
    REG_MIRROR_LIDS  = 3'd5,
    REG_FORCE_CLOSED = 3'd6
  } reg_idx_t;

endpackage
`default_nettype wire

// ----- hdl/eye_pixel_compositor.sv -----
// Eye pixel compositor: store loading and four-stage pixel render pipeline.
// One request per cycle unless in_stall is high; the texture read waits on the polar map read
// and the dilation multiply, so the pipeline has lid/sclera/polar read, multiply,
// texture read and output stages. Loads write each store at the stage that reads it.
// Reset clears valid bits and loads config registers with defaults; stores are not cleared.
`default_nettype none
module eye_pixel_compositor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] table_addr,
  input  wire logic [15:0] table_data,
  input  wire logic [6:0]  pixel_x,
  input  wire logic [6:0]  pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      pixel_color,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // config registers
  logic [eyepc_pkg::SCALE_W-1:0] iris_scale;
  logic [6:0] view_offset_x;
  logic [6:0] view_offset_y;
  logic [7:0] upper_lid_threshold;
  logic [7:0] lower_lid_threshold;
  logic       mirror_lids;
  logic       force_closed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iris_scale          <= 10'd512;
      view_offset_x       <= 7'd36;
      view_offset_y       <= 7'd36;
      upper_lid_threshold <= 8'd128;
      lower_lid_threshold <= 8'd126;
      mirror_lids         <= 1'b0;
      force_closed        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (eyepc_pkg::reg_idx_t'(cfg_index))
        eyepc_pkg::REG_IRIS_SCALE:   iris_scale <= cfg_data;
        eyepc_pkg::REG_VIEW_X:       view_offset_x <= cfg_data[6:0];
        eyepc_pkg::REG_VIEW_Y:       view_offset_y <= cfg_data[6:0];
        eyepc_pkg::REG_UPPER_THR:    upper_lid_threshold <= cfg_data[7:0];
        eyepc_pkg::REG_LOWER_THR:    lower_lid_threshold <= cfg_data[7:0];
        eyepc_pkg::REG_MIRROR_LIDS:  mirror_lids <= cfg_data[0];
        eyepc_pkg::REG_FORCE_CLOSED: force_closed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control: only a render waiting on a full, stalled output freezes the pipe
  logic d_render;
  logic adv;
  logic accept;

  assign adv      = !(d_render && out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // ---------------- stage A: decode, address generation, first reads
  logic wr_lower, wr_upper, wr_sclera, wr_polar, wr_tex, is_render;
  logic off_screen, in_win, scl_ok;
  logic [eyepc_pkg::LID_XW-1:0] lid_x;
  logic [eyepc_pkg::LID_AW-1:0] lid_idx;
  logic [eyepc_pkg::SX_W-1:0]   sx, sy, ix, iy;
  logic [eyepc_pkg::SCL_AW-1:0] scl_addr;
  logic [eyepc_pkg::POL_AW-1:0] pol_addr;

  always_comb begin
    wr_lower  = 1'b0;
    wr_upper  = 1'b0;
    wr_sclera = 1'b0;
    wr_polar  = 1'b0;
    wr_tex    = 1'b0;
    is_render = 1'b0;
    case (eyepc_pkg::op_t'(op))
      eyepc_pkg::OP_LOWER_LID: wr_lower  = accept && (32'(table_addr) < eyepc_pkg::LID_DEPTH);
      eyepc_pkg::OP_UPPER_LID: wr_upper  = accept && (32'(table_addr) < eyepc_pkg::LID_DEPTH);
      eyepc_pkg::OP_SCLERA:
        wr_sclera = accept && (32'(table_addr) < eyepc_pkg::SCLERA_DEPTH);
      eyepc_pkg::OP_POLAR:
        wr_polar = accept && (32'(table_addr) < eyepc_pkg::POLAR_DEPTH);
      eyepc_pkg::OP_TEXTURE:
        wr_tex = accept && (32'(table_addr) < eyepc_pkg::TEXTURE_DEPTH);
      eyepc_pkg::OP_RENDER:    is_render = accept;
      default: ;
    endcase
  end

  always_comb begin
    off_screen = (32'(pixel_x) >= eyepc_pkg::SCREEN_SIZE) ||
                 (32'(pixel_y) >= eyepc_pkg::SCREEN_SIZE);
    lid_x   = mirror_lids ? eyepc_pkg::LID_XW'(eyepc_pkg::SCREEN_SIZE - 1 - 32'(pixel_x))
                          : eyepc_pkg::LID_XW'(pixel_x);
    lid_idx = eyepc_pkg::LID_AW'(32'(pixel_y) * eyepc_pkg::SCREEN_SIZE + 32'(lid_x));
    sx = {1'b0, view_offset_x} + {1'b0, pixel_x};
    sy = {1'b0, view_offset_y} + {1'b0, pixel_y};
    scl_ok = (32'(sx) < eyepc_pkg::SCLERA_SIZE) && (32'(sy) < eyepc_pkg::SCLERA_SIZE);
    in_win = (32'(sx) >= eyepc_pkg::IRIS_ORG) &&
             (32'(sx) <  eyepc_pkg::IRIS_ORG + eyepc_pkg::IRIS_SIZE) &&
             (32'(sy) >= eyepc_pkg::IRIS_ORG) &&
             (32'(sy) <  eyepc_pkg::IRIS_ORG + eyepc_pkg::IRIS_SIZE);
    ix = eyepc_pkg::SX_W'(32'(sx) - eyepc_pkg::IRIS_ORG);
    iy = eyepc_pkg::SX_W'(32'(sy) - eyepc_pkg::IRIS_ORG);
    scl_addr = scl_ok ? eyepc_pkg::SCL_AW'(32'(sy) * eyepc_pkg::SCLERA_SIZE + 32'(sx)) : '0;
    pol_addr = in_win ? eyepc_pkg::POL_AW'(32'(iy) * eyepc_pkg::IRIS_SIZE + 32'(ix)) : '0;
  end

  logic [7:0]  lower_mem [eyepc_pkg::LID_DEPTH];
  logic [7:0]  upper_mem [eyepc_pkg::LID_DEPTH];
  logic [15:0] sclera_mem [eyepc_pkg::SCLERA_DEPTH];
  logic [15:0] polar_mem [eyepc_pkg::POLAR_DEPTH];
  logic [15:0] tex_mem [eyepc_pkg::TEXTURE_DEPTH];

  logic [7:0]  lower_rd, upper_rd;
  logic [15:0] sclera_rd, polar_rd, tex_rd;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_lower) lower_mem[table_addr[eyepc_pkg::LID_AW-1:0]] <= table_data[7:0];
      lower_rd <= lower_mem[lid_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_upper) upper_mem[table_addr[eyepc_pkg::LID_AW-1:0]] <= table_data[7:0];
      upper_rd <= upper_mem[lid_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_sclera) sclera_mem[table_addr[eyepc_pkg::SCL_AW-1:0]] <= table_data;
      sclera_rd <= sclera_mem[scl_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_polar) polar_mem[table_addr[eyepc_pkg::POL_AW-1:0]] <= table_data;
      polar_rd <= polar_mem[pol_addr];
    end
  end

  // ---------------- stage B: lid test, dilation multiply
  logic b_render, b_off, b_in_win, b_scl_ok, b_tex_wr;
  logic [eyepc_pkg::TEX_AW-1:0] b_tex_addr;
  logic [15:0] b_tex_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_render <= 1'b0;
      b_tex_wr <= 1'b0;
    end else if (adv) begin
      b_render <= is_render;
      b_tex_wr <= wr_tex;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_off      <= off_screen;
      b_in_win   <= in_win;
      b_scl_ok   <= scl_ok;
      b_tex_addr <= table_addr[eyepc_pkg::TEX_AW-1:0];
      b_tex_data <= table_data;
    end
  end

  logic [7:0] ut, lt;
  logic b_black;
  logic [eyepc_pkg::PROD_W-1:0] b_prod;

  always_comb begin
    ut = force_closed ? eyepc_pkg::THR_CLOSED : upper_lid_threshold;
    lt = force_closed ? eyepc_pkg::THR_CLOSED : lower_lid_threshold;
    b_black = b_off || (lower_rd <= lt) || (upper_rd <= ut);
    b_prod = {{eyepc_pkg::RAD_W{1'b0}}, iris_scale} *
             {{eyepc_pkg::SCALE_W{1'b0}}, polar_rd[eyepc_pkg::RAD_W-1:0]};
  end

  // ---------------- stage C: texture address and read, texture loads
  logic c_render, c_black, c_in_win, c_scl_ok, c_tex_wr;
  logic [eyepc_pkg::PROD_W-1:0] c_prod;
  logic [eyepc_pkg::ANG_W-1:0]  c_ang;
  logic [15:0] c_sclera;
  logic [eyepc_pkg::TEX_AW-1:0] c_tex_addr;
  logic [15:0] c_tex_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_render <= 1'b0;
      c_tex_wr <= 1'b0;
    end else if (adv) begin
      c_render <= b_render;
      c_tex_wr <= b_tex_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_black    <= b_black;
      c_in_win   <= b_in_win;
      c_scl_ok   <= b_scl_ok;
      c_prod     <= b_prod;
      c_ang      <= polar_rd[15:eyepc_pkg::RAD_W];
      c_sclera   <= sclera_rd;
      c_tex_addr <= b_tex_addr;
      c_tex_data <= b_tex_data;
    end
  end

  logic [eyepc_pkg::DIST_W-1:0] radius;
  logic [eyepc_pkg::COL_W-1:0]  col;
  logic use_tex;
  logic [eyepc_pkg::TEX_AW-1:0] tex_rd_addr;

  always_comb begin
    radius = eyepc_pkg::DIST_W'(32'(c_prod) / eyepc_pkg::SCALE_DIV);
    col  = eyepc_pkg::COL_W'((eyepc_pkg::IRIS_MAP_COLS * 32'(c_ang)) / eyepc_pkg::ANG_DIV);
    use_tex = c_in_win && (32'(radius) < eyepc_pkg::IRIS_MAP_ROWS);
    tex_rd_addr = use_tex ?
        eyepc_pkg::TEX_AW'(32'(radius) * eyepc_pkg::IRIS_MAP_COLS + 32'(col)) : '0;
  end

  // texture loads ride the pipe to this stage, so they stay ordered with reads
  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_tex_wr) tex_mem[c_tex_addr] <= c_tex_data;
      tex_rd <= tex_mem[tex_rd_addr];
    end
  end

  // ---------------- stage D: select and output register
  logic d_black, d_use_tex, d_scl_ok;
  logic [15:0] d_sclera;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_render <= 1'b0;
    end else if (adv) begin
      d_render <= c_render;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_black   <= c_black;
      d_use_tex <= use_tex;
      d_scl_ok  <= c_scl_ok;
      d_sclera  <= c_sclera;
    end
  end

  logic [15:0] texel, color_next;

  always_comb begin
    texel = d_use_tex ? tex_rd : (d_scl_ok ? d_sclera : eyepc_pkg::BLACK);
    color_next = d_black ? eyepc_pkg::BLACK : {texel[7:0], texel[15:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && d_render) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_render) pixel_color <= color_next;
  end

  // ---------------- checks
  a_render_lands: assert property (@(posedge clk) disable iff (rst)
    adv && d_render |=> out_valid)
    else $error("render request did not reach output");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    adv && d_render && d_black |=> pixel_color == eyepc_pkg::BLACK)
    else $error("lid-covered pixel not black");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && d_render |=> $stable(pixel_color) && out_valid)
    else $error("stalled result overwritten");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    c_render && use_tex |-> 32'(tex_rd_addr) < eyepc_pkg::TEXTURE_DEPTH)
    else $error("texture address out of range");

endmodule
`default_nettype wire
